FILE: hdl/rpa_pkg.sv
// ----------------------------------------------------------------------------
// Rotate point by arc length: shared package
// Widths, fixed-point constants, tables and types used across the design.
// ----------------------------------------------------------------------------
`default_nettype none

package rpa_pkg;

  // Field and datapath widths.
  localparam int unsigned CW        = 24;   // coordinate width
  localparam int unsigned RW        = 23;   // radius width
  localparam int unsigned AW        = 24;   // angle width (Q7.16)
  localparam int unsigned VW        = 43;   // rotator x/y width (16 guard bits)
  localparam int unsigned ZW        = 32;   // residual angle width (Q28)
  localparam int unsigned GUARD     = 16;
  localparam int unsigned DIV_STEPS = 24;   // quotient bits below the overflow check
  localparam int unsigned ATAN_LEN  = 24;
  localparam int unsigned ROTATION_STAGES_DEF = 16;

  // Register reset values.
  localparam logic signed [CW-1:0] CENTER_X_RST = 24'sd102400;
  localparam logic signed [CW-1:0] CENTER_Y_RST = 24'sd76800;
  localparam logic [RW-1:0]        RADIUS_RST   = 23'd38400;
  localparam logic signed [CW-1:0] ARC_RST      = 24'sd0;

  // Angle constants in Q28 radians.
  localparam logic signed [ZW-1:0] Q28_TWO_PI  = 32'sd1686629713;
  localparam logic [30:0]          Q28_TWO_PI_U = 31'd1686629713;
  localparam logic signed [ZW-1:0] Q28_PI      = 32'sd843314857;
  localparam logic signed [ZW-1:0] Q28_HALF_PI = 32'sd421657428;

  // CORDIC gain compensation in Q30.
  localparam logic signed [30:0] GAIN_Q30 = 31'sd652032874;

  // Reciprocal of 2*pi (Q28) scaled so that (mag * RED_RECIP) >> 40 estimates
  // floor(mag * 2^12 / 2*pi) low by at most one.
  localparam logic [21:0] RED_RECIP = 22'((64'd1 << 52) / 64'd1686629713);

  localparam logic signed [CW-1:0] MAX24 = 24'sh7FFFFF;
  localparam logic signed [CW-1:0] MIN24 = 24'sh800000;

  // Arctangent of 2^-i in Q28.
  localparam logic signed [ZW-1:0] ATAN_Q28 [ATAN_LEN] = '{
    32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
    32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
    32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
    32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
    32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
    32'sd256,       32'sd128,       32'sd64,       32'sd32
  };

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2,
    CFG_ARC      = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
  } vec_t;

  // Restoring divider state carried from cell to cell.
  typedef struct packed {
    logic [39:0]   rem;
    logic [AW-1:0] quo;
    logic          neg;
    logic          ovf;
    logic          zero;
  } div_t;

  // Rotator state carried from cell to cell.
  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [AW-1:0]        ang;
  } cor_t;

  typedef struct packed {
    logic [CW-1:0] offset_x;
    logic [CW-1:0] offset_y;
    logic [AW-1:0] angle_used;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/rpa_stream_if.sv
// ----------------------------------------------------------------------------
// Rotate point by arc length: stream interfaces
// Valid/ready channels for input points and rotated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpa_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface rpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] offset_x;
  logic signed [23:0] offset_y;
  logic signed [23:0] angle_used;
  modport source (output valid, offset_x, offset_y, angle_used, input ready);
  modport sink   (input valid, offset_x, offset_y, angle_used, output ready);
endinterface

`default_nettype wire

FILE: hdl/rotate_point_by_arc_length.sv
// ----------------------------------------------------------------------------
// Rotate point by arc length: top level
// Rotates each input point about a configured center by arc/radius radians.
// ----------------------------------------------------------------------------
// Usage: points arrive on pnt_i and rotated points leave on res_o, both
// valid/ready streams; one result beat leaves for every accepted input beat,
// in order. Registers (center_x, center_y, radius, arc_offset) are written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write them only while
// no point is in flight; the block does not enforce it. There are two front
// stages, 24 divider cells, one saturation stage, five angle-reduction
// stages, one CORDIC cell per rotation stage up to the arctangent table's
// length, one output stage and the output register. While the skid register
// is empty a new point is taken every cycle; the row moves one beat per clock.
// When the receiver stalls, the pipeline keeps moving until one result sits
// in the output register and one in the skid register; pnt_i.ready then
// drops until the skid register drains.
// Reset empties the pipeline and returns the registers to their defaults
// (center 400.0/300.0, radius 150.0, arc 0).
// ----------------------------------------------------------------------------
`default_nettype none

module rotate_point_by_arc_length import rpa_pkg::*; #(
  parameter int unsigned ROTATION_STAGES = ROTATION_STAGES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [CW-1:0] cfg_data_i,
  rpa_in_if.sink             pnt_i,
  rpa_out_if.source          res_o
);

  localparam int unsigned NCELL =
    (ROTATION_STAGES < ATAN_LEN) ? ROTATION_STAGES : ATAN_LEN;

  // Configuration registers.
  logic signed [CW-1:0] cx_q, cy_q, arc_q;
  logic [RW-1:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= CENTER_X_RST;
      cy_q  <= CENTER_Y_RST;
      rad_q <= RADIUS_RST;
      arc_q <= ARC_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_X: cx_q  <= cfg_data_i;
        CFG_CENTER_Y: cy_q  <= cfg_data_i;
        CFG_RADIUS:   rad_q <= cfg_data_i[RW-1:0];
        CFG_ARC:      arc_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // The whole row advances unless the skid register holds a beat.
  logic pipe_en;
  logic skid_v_q;
  assign pipe_en     = !skid_v_q;
  assign pnt_i.ready = pipe_en;

  // Front stage: vector from center, divider setup.
  logic [CW-1:0]        arc_abs;
  div_t                 div_init;
  logic                 p0_v_q;
  logic signed [CW:0]   dx_q, dy_q;
  div_t                 p0_div_q;

  assign arc_abs = arc_q[CW-1] ? CW'(-arc_q) : arc_q;

  always_comb begin
    div_init.rem  = {arc_abs, 16'b0};
    div_init.quo  = '0;
    div_init.neg  = arc_q[CW-1];
    div_init.ovf  = ({7'b0, arc_abs} >= {rad_q, 8'b0});
    div_init.zero = (arc_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (pipe_en) begin
      p0_v_q <= pnt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dx_q     <= (CW+1)'(pnt_i.point_x) - (CW+1)'(cx_q);
      dy_q     <= (CW+1)'(pnt_i.point_y) - (CW+1)'(cy_q);
      p0_div_q <= div_init;
    end
  end

  // Gain compensation, rounded half up to 16 guard bits.
  logic signed [55:0] mx, my;
  logic               p1_v_q;
  vec_t               p1_vec_q;
  div_t               p1_div_q;

  assign mx = dx_q * GAIN_Q30;
  assign my = dy_q * GAIN_Q30;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (pipe_en) begin
      p1_v_q <= p0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      p1_vec_q.x <= VW'((mx + 56'sd8192) >>> 14);
      p1_vec_q.y <= VW'((my + 56'sd8192) >>> 14);
      p1_div_q   <= p0_div_q;
    end
  end

  // Divider row: cell k decides quotient bit DIV_STEPS-1-k.
  logic dv [DIV_STEPS+1];
  div_t dd [DIV_STEPS+1];
  vec_t dvec [DIV_STEPS+1];

  assign dv[0]   = p1_v_q;
  assign dd[0]   = p1_div_q;
  assign dvec[0] = p1_vec_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rpa_div_cell #(.STEP(DIV_STEPS - 1 - k)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (pipe_en),
      .valid_i  (dv[k]),
      .div_i    (dd[k]),
      .vec_i    (dvec[k]),
      .radius_i (rad_q),
      .valid_o  (dv[k+1]),
      .div_o    (dd[k+1]),
      .vec_o    (dvec[k+1])
    );
  end

  // Saturate the quotient; keep magnitude and sign for the reduction.
  div_t          dq;
  logic [AW-1:0] mag_d;
  logic          a_v_q, a_neg_q;
  logic [AW-1:0] a_mag_q, a_ang_q;
  vec_t          a_vec_q;

  assign dq = dd[DIV_STEPS];

  always_comb begin
    if (dq.zero) begin
      mag_d = '0;
    end else if (dq.ovf || dq.quo[AW-1]) begin
      mag_d = dq.neg ? 24'h800000 : 24'h7FFFFF;
    end else begin
      mag_d = dq.quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (pipe_en) begin
      a_v_q <= dv[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_mag_q <= mag_d;
      a_neg_q <= dq.neg;
      a_ang_q <= dq.neg ? AW'(-mag_d) : mag_d;
      a_vec_q <= dvec[DIV_STEPS];
    end
  end

  // Reduction, first step: estimate how many turns the angle holds.
  logic [45:0]   r1_prod;
  logic          r1_v_q, r1_neg_q;
  logic [5:0]    r1_k_q;
  logic [AW-1:0] r1_mag_q, r1_ang_q;
  vec_t          r1_vec_q;

  assign r1_prod = a_mag_q * RED_RECIP;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_v_q <= 1'b0;
    end else if (pipe_en) begin
      r1_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r1_k_q   <= r1_prod[45:40];
      r1_mag_q <= a_mag_q;
      r1_neg_q <= a_neg_q;
      r1_ang_q <= a_ang_q;
      r1_vec_q <= a_vec_q;
    end
  end

  // Reduction, second step: subtract the estimated turns.
  logic [36:0]   r2_kp, r2_diff;
  logic          r2_v_q, r2_neg_q;
  logic [31:0]   r2_r_q;
  logic [AW-1:0] r2_ang_q;
  vec_t          r2_vec_q;

  assign r2_kp   = r1_k_q * Q28_TWO_PI_U;
  assign r2_diff = {1'b0, r1_mag_q, 12'b0} - r2_kp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_v_q <= 1'b0;
    end else if (pipe_en) begin
      r2_v_q <= r1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r2_r_q   <= r2_diff[31:0];
      r2_neg_q <= r1_neg_q;
      r2_ang_q <= r1_ang_q;
      r2_vec_q <= r1_vec_q;
    end
  end

  // Reduction, third step: correct an estimate that was one turn low.
  logic          r3_v_q, r3_neg_q;
  logic [31:0]   r3_rc_q;
  logic [AW-1:0] r3_ang_q;
  vec_t          r3_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r3_v_q <= 1'b0;
    end else if (pipe_en) begin
      r3_v_q <= r2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r3_rc_q  <= (r2_r_q >= {1'b0, Q28_TWO_PI_U}) ? r2_r_q - {1'b0, Q28_TWO_PI_U}
                                                  : r2_r_q;
      r3_neg_q <= r2_neg_q;
      r3_ang_q <= r2_ang_q;
      r3_vec_q <= r2_vec_q;
    end
  end

  // Reduction, fourth step: restore the sign and wrap into [-pi, pi].
  logic signed [ZW-1:0] r4_m;
  logic                 r4_v_q;
  logic signed [ZW-1:0] r4_z_q;
  logic [AW-1:0]        r4_ang_q;
  vec_t                 r4_vec_q;

  assign r4_m = ($signed(r3_rc_q) > Q28_PI) ? $signed(r3_rc_q) - Q28_TWO_PI
                                             : $signed(r3_rc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r4_v_q <= 1'b0;
    end else if (pipe_en) begin
      r4_v_q <= r3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r4_z_q   <= r3_neg_q ? -r4_m : r4_m;
      r4_ang_q <= r3_ang_q;
      r4_vec_q <= r3_vec_q;
    end
  end

  // Fold angles beyond a quarter turn by a half turn and negate the vector.
  cor_t r5_d;
  logic r5_v_q;
  cor_t r5_cor_q;

  always_comb begin
    r5_d.x   = r4_vec_q.x;
    r5_d.y   = r4_vec_q.y;
    r5_d.z   = r4_z_q;
    r5_d.ang = r4_ang_q;
    if (r4_z_q > Q28_HALF_PI) begin
      r5_d.z = r4_z_q - Q28_PI;
      r5_d.x = -r4_vec_q.x;
      r5_d.y = -r4_vec_q.y;
    end else if (r4_z_q < -Q28_HALF_PI) begin
      r5_d.z = r4_z_q + Q28_PI;
      r5_d.x = -r4_vec_q.x;
      r5_d.y = -r4_vec_q.y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r5_v_q <= 1'b0;
    end else if (pipe_en) begin
      r5_v_q <= r4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      r5_cor_q <= r5_d;
    end
  end

  // CORDIC row.
  logic cv [NCELL+1];
  cor_t cc [NCELL+1];

  assign cv[0] = r5_v_q;
  assign cc[0] = r5_cor_q;

  for (genvar k = 0; k < NCELL; k++) begin : g_cordic
    rpa_cordic_cell #(.STEP(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (cv[k]),
      .cor_i   (cc[k]),
      .valid_o (cv[k+1]),
      .cor_o   (cc[k+1])
    );
  end

  // Round back to coordinate precision, add the center, saturate.
  cor_t               cf;
  logic signed [27:0] sx, sy;
  logic               f_v_q;
  res_t               f_res_q;
  res_t               f_res_d;

  assign cf = cc[NCELL];
  assign sx = 28'(cx_q) + 28'((cf.x + VW'(1 << (GUARD - 1))) >>> GUARD);
  assign sy = 28'(cy_q) + 28'((cf.y + VW'(1 << (GUARD - 1))) >>> GUARD);

  always_comb begin
    f_res_d.angle_used = cf.ang;
    if (!sx[27] && (|sx[26:23]))      f_res_d.offset_x = MAX24;
    else if (sx[27] && !(&sx[26:23])) f_res_d.offset_x = MIN24;
    else                              f_res_d.offset_x = sx[23:0];
    if (!sy[27] && (|sy[26:23]))      f_res_d.offset_y = MAX24;
    else if (sy[27] && !(&sy[26:23])) f_res_d.offset_y = MIN24;
    else                              f_res_d.offset_y = sy[23:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (pipe_en) begin
      f_v_q <= cv[NCELL];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      f_res_q <= f_res_d;
    end
  end

  // Output register with a skid register behind it.
  logic fire;
  logic out_v_q;
  res_t out_q, skid_q;

  assign fire = pipe_en && f_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || res_o.ready) begin
      out_v_q  <= skid_v_q || fire;
      skid_v_q <= 1'b0;
    end else if (fire) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || res_o.ready) begin
      out_q <= skid_v_q ? skid_q : f_res_q;
    end else if (fire) begin
      skid_q <= f_res_q;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.offset_x   = out_q.offset_x;
  assign res_o.offset_y   = out_q.offset_y;
  assign res_o.angle_used = out_q.angle_used;

`ifndef NO_ASSERTIONS
  // A beat only waits in the skid register behind a held output beat.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full while output register empty");

  // The turn estimate is corrected to a remainder below one full turn.
  a_reduced_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r3_v_q |-> (r3_rc_q < {1'b0, Q28_TWO_PI_U}))
    else $error("angle reduction left a full turn");

  // The rotator starts within a quarter turn.
  a_quarter_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r5_v_q |-> ((r5_cor_q.z <= Q28_HALF_PI) && (r5_cor_q.z >= -Q28_HALF_PI)))
    else $error("rotator angle outside a quarter turn");
`endif

endmodule

`default_nettype wire

FILE: hdl/rpa_div_cell.sv
// ----------------------------------------------------------------------------
// Rotate point by arc length: divider cell
// One restoring division step; decides one quotient bit of arc/radius.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_div_cell import rpa_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire div_t          div_i,
  input  wire vec_t          vec_i,
  input  wire logic [RW-1:0] radius_i,
  output      logic          valid_o,
  output      div_t          div_o,
  output      vec_t          vec_o
);

  logic [46:0] trial;
  div_t        div_d;
  logic        valid_q;
  div_t        div_q;
  vec_t        vec_q;

  // Trial subtraction of the shifted divisor.
  assign trial = {7'b0, div_i.rem} - ({24'b0, radius_i} << STEP);

  always_comb begin
    div_d = div_i;
    if (!trial[46]) begin
      div_d.rem       = trial[39:0];
      div_d.quo[STEP] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
      vec_q <= vec_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;
  assign vec_o   = vec_q;

endmodule

`default_nettype wire

FILE: hdl/rpa_cordic_cell.sv
// ----------------------------------------------------------------------------
// Rotate point by arc length: CORDIC cell
// One micro-rotation by the arctangent of 2^-STEP.
// ----------------------------------------------------------------------------
`default_nettype none

module rpa_cordic_cell import rpa_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire cor_t cor_i,
  output      logic valid_o,
  output      cor_t cor_o
);

  logic signed [VW-1:0] xs;
  logic signed [VW-1:0] ys;
  cor_t                 cor_d;
  logic                 valid_q;
  cor_t                 cor_q;

  // Arithmetic shifts floor toward minus infinity.
  assign xs = cor_i.x >>> STEP;
  assign ys = cor_i.y >>> STEP;

  always_comb begin
    cor_d = cor_i;
    if (!cor_i.z[ZW-1]) begin
      cor_d.x = cor_i.x - ys;
      cor_d.y = cor_i.y + xs;
      cor_d.z = cor_i.z - ATAN_Q28[STEP];
    end else begin
      cor_d.x = cor_i.x + ys;
      cor_d.y = cor_i.y - xs;
      cor_d.z = cor_i.z + ATAN_Q28[STEP];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cor_q <= cor_d;
    end
  end

  assign valid_o = valid_q;
  assign cor_o   = cor_q;

endmodule

`default_nettype wire
